// ----- design/hcp_pkg.sv -----
`timescale 1ns / 1ps

package hcp_pkg;

  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int SYM_W  = 8;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  // One unit of work for the packer: an append of a nonzero-length code or a flush.
  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hcp_entry_t;

endpackage

// ----- design/hcp_front.sv -----
`timescale 1ns / 1ps

module hcp_front #(
  parameter int WORD_BITS   = 32,
  parameter int TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [hcp_pkg::OP_W-1:0]  operation,
  input  logic [hcp_pkg::SYM_W-1:0] symbol,
  input  logic [hcp_pkg::CODE_W-1:0] code_bits,
  input  logic [hcp_pkg::LEN_W-1:0] code_length,
  input  logic                      q_full,
  output logic                      q_push,
  output hcp_pkg::hcp_entry_t       q_entry
);
  import hcp_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_MAX_I = (WORD_BITS < CODE_W) ? WORD_BITS : CODE_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEN_MAX_I);
  localparam logic [SYM_W:0] DEPTH_X = (SYM_W + 1)'(TABLE_DEPTH);

  logic [CODE_W+LEN_W-1:0] mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  tbl_valid;

  logic                    accept;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;
  logic [LEN_W-1:0]        load_len;

  // stage 1: table read result
  logic                    s1_valid;
  logic [OP_W-1:0]         s1_op;
  logic                    s1_in_range;
  logic                    s1_hit;
  logic [CODE_W+LEN_W-1:0] s1_rd;

  logic [CODE_W-1:0]       rd_code;
  logic [LEN_W-1:0]        rd_len;
  logic                    advance;

  assign accept   = item_valid && item_ready;
  assign in_range = {1'b0, symbol} < DEPTH_X;
  assign idx      = symbol[IDX_W-1:0];
  assign load_len = (code_length > LEN_MAX) ? LEN_MAX : code_length;

  assign advance    = s1_valid && !q_full;
  assign item_ready = !s1_valid || !q_full;

  always_ff @(posedge clk) begin
    if (accept && operation == OP_LOAD && in_range) begin
      mem[idx] <= {code_bits, load_len};
    end
    if (accept) begin
      s1_rd <= mem[idx];
      s1_hit <= tbl_valid[idx];
      s1_op <= operation;
      s1_in_range <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept && operation == OP_LOAD && in_range) begin
        tbl_valid[idx] <= 1'b1;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  assign rd_len  = s1_hit ? s1_rd[LEN_W-1:0] : '0;
  assign rd_code = s1_rd[CODE_W+LEN_W-1:LEN_W]
                   & ~({CODE_W{1'b1}} << rd_len);

  always_comb begin
    q_entry.flush = (s1_op == OP_FLUSH);
    q_entry.code  = rd_code;
    q_entry.len   = rd_len;
    q_push        = 1'b0;
    if (advance) begin
      if (s1_op == OP_FLUSH) begin
        q_push = 1'b1;
      end else if (s1_op == OP_ENCODE && s1_in_range && rd_len != '0) begin
        q_push = 1'b1;
      end
    end
  end

endmodule

// ----- design/hcp_queue.sv -----
`timescale 1ns / 1ps

module hcp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hcp_pkg::hcp_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                nonempty,
  output hcp_pkg::hcp_entry_t head
);
  import hcp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hcp_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/hcp_back.sv -----
`timescale 1ns / 1ps

module hcp_back #(
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_nonempty,
  input  hcp_pkg::hcp_entry_t          q_head,
  output logic                         q_pop,
  output logic                         word_valid,
  input  logic                         word_ready,
  output logic [hcp_pkg::CODE_W-1:0]   packed_word,
  output logic [hcp_pkg::LEN_W-1:0]    valid_bits,
  output logic                         final_word
);
  import hcp_pkg::*;

  localparam int HELD_W = $clog2(WORD_BITS + 1);
  localparam int CW     = (HELD_W > LEN_W) ? HELD_W : LEN_W;
  localparam logic [CW-1:0]    W_X      = CW'(WORD_BITS);
  localparam logic [LEN_W-1:0] FULL_CNT = LEN_W'(WORD_BITS);

  logic [WORD_BITS-1:0] pw;
  logic [HELD_W-1:0]    held;

  logic [WORD_BITS-1:0] pw_next;
  logic [HELD_W-1:0]    held_next;
  logic                 emit;
  logic [WORD_BITS-1:0] word;
  logic [LEN_W-1:0]     word_cnt;

  logic [WORD_BITS-1:0] code_w;
  logic [CW-1:0]        held_x;
  logic [CW-1:0]        len_x;
  logic [CW-1:0]        space;
  logic [CW-1:0]        rest;

  assign q_pop = q_nonempty && (!word_valid || word_ready);

  assign code_w = WORD_BITS'(q_head.code);
  assign held_x = CW'(held);
  assign len_x  = CW'(q_head.len);
  assign space  = W_X - held_x;
  assign rest   = len_x - space;

  always_comb begin
    pw_next   = pw;
    held_next = held;
    emit      = 1'b0;
    word      = '0;
    word_cnt  = FULL_CNT;
    if (q_head.flush) begin
      if (held != '0) begin
        emit      = 1'b1;
        word      = pw << (W_X - held_x);
        word_cnt  = LEN_W'(held);
        pw_next   = '0;
        held_next = '0;
      end
    end else if (len_x < space) begin
      pw_next   = (pw << len_x) | code_w;
      held_next = HELD_W'(held_x + len_x);
    end else begin
      // code spills: top bits complete the word, the rest starts the next one
      emit      = 1'b1;
      word      = (pw << space) | (code_w >> rest);
      pw_next   = code_w & ~({WORD_BITS{1'b1}} << rest);
      held_next = HELD_W'(rest);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pw <= '0;
      held <= '0;
      word_valid <= 1'b0;
    end else begin
      // a pop only happens when the output register is free or being drained
      if (q_pop) begin
        word_valid <= emit;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end
      if (q_pop) begin
        pw <= pw_next;
        held <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      packed_word <= CODE_W'(word);
      valid_bits <= word_cnt;
      final_word <= q_head.flush;
    end
  end

endmodule

// ----- design/huffman_code_table_bit_packer.sv -----
`timescale 1ns / 1ps

// Huffman bit packer with a loadable code table. Items enter at one per cycle
// while the queue has room; the front end does the table write or the
// registered table read (one port each way per cycle), a four-entry queue
// decouples it from the packer, which appends one code or flushes per cycle
// while its output register (it holds the finished word) is free or draining.
// Items ending a word pass stage 1 and the queue to the output register.
// The code table resets to all zero-length codes at once; no clearing pass needed.
module huffman_code_table_bit_packer #(
  parameter int WORD_BITS   = 32,
  parameter int TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [hcp_pkg::OP_W-1:0]      operation,
  input  logic [hcp_pkg::SYM_W-1:0]     symbol,
  input  logic [hcp_pkg::CODE_W-1:0]    code_bits,
  input  logic [hcp_pkg::LEN_W-1:0]     code_length,
  output logic                          word_valid,
  input  logic                          word_ready,
  output logic [hcp_pkg::CODE_W-1:0]    packed_word,
  output logic [hcp_pkg::LEN_W-1:0]     valid_bits,
  output logic                          final_word
);
  import hcp_pkg::*;

  localparam logic [LEN_W-1:0] FULL_CNT = LEN_W'(WORD_BITS);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_nonempty;
  hcp_entry_t q_in;
  hcp_entry_t q_head;

  hcp_front #(
    .WORD_BITS  (WORD_BITS),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .operation  (operation),
    .symbol     (symbol),
    .code_bits  (code_bits),
    .code_length(code_length),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  hcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_in),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  hcp_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .packed_word(packed_word),
    .valid_bits (valid_bits),
    .final_word (final_word)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("queue push while full");

  a_full_word_count: assert property (@(posedge clk) disable iff (rst)
    word_valid && !final_word |-> valid_bits == FULL_CNT)
    else $error("non-final word with partial count");

  a_final_nonempty: assert property (@(posedge clk) disable iff (rst)
    word_valid && final_word |-> valid_bits != '0)
    else $error("flush word with zero bits");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !word_valid && !q_nonempty)
    else $error("activity right after reset");

endmodule
